// ===== sv/bfq_pkg.sv =====
// Shared types and constants of the bounded FIFO with take marker.
package bfq_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int ENTRY_WIDTH_DEF = 64;
  localparam int DATA_W          = 64;
  localparam int OCC_W           = 7;
  localparam int CFG_W           = 7;
  localparam int CODE_W          = 3;

  typedef enum logic [CODE_W-1:0] {
    OP_WRITE     = 3'd0,
    OP_TAKE      = 3'd1,
    OP_PEEK      = 3'd2,
    OP_SET_MARK  = 3'd3,
    OP_CLR_MARK  = 3'd4
  } bfq_op_t;

  typedef enum logic [CODE_W-1:0] {
    STS_OK      = 3'd0,
    STS_FULL    = 3'd1,
    STS_IGNORED = 3'd2,
    STS_EMPTY   = 3'd3,
    STS_HELD    = 3'd4
  } bfq_status_t;

  // Write kinds at or below this code are control kinds and are not stored.
  localparam logic [CODE_W-1:0] KIND_UNREGISTER = 3'd1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } bfq_state_t;

  typedef struct packed {
    logic [CODE_W-1:0] opcode;
    logic [CODE_W-1:0] action_kind;
    logic [DATA_W-1:0] entry_data;
  } bfq_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] status;
    logic              entry_valid;
    logic [DATA_W-1:0] entry_out;
    logic [OCC_W-1:0]  occupancy;
    logic              data_available;
    logic              marker_held;
  } bfq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;     // commit the operation of the accepted transaction
    logic capture;  // load the memory read data into the result register
  } bfq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_read;
  } bfq_stat_t;

endpackage

// ===== sv/bfq_if.sv =====
// Valid/ready channel interfaces for operations and results.
interface bfq_in_if;
  logic             valid;
  logic             ready;
  bfq_pkg::bfq_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bfq_out_if;
  logic              valid;
  logic              ready;
  bfq_pkg::bfq_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/bounded_fifo_with_take_marker_core.sv =====
// Top level of the bounded FIFO with take marker: controller, datapath and checks.
//
// Usage: each transaction on in_ch is one queue operation (write, take, peek
// head, set marker, clear marker); each produces exactly one transaction on
// out_ch carrying status, the entry word for take and peek, occupancy after
// the operation, data available and the marker-held flag.
// The capacity limit max_entries is written through cfg_wr_en/cfg_wr_data
// while the block is idle; zero means the full ring depth.
// Writes, marker operations and rejected operations return their result in the
// cycle after acceptance and allow one operation per cycle while the receiver
// takes each result. A take or peek that returns an entry passes through
// ST_READ, where the registered read of the entry memory is captured, before
// its result is presented. in_ch.ready is high whenever the result register
// is empty or is being emptied in the same cycle and no memory read is pending.
// Reset (synchronous, active low) empties the queue, disables the marker and
// sets the capacity limit to zero; memory contents are not cleared.
// When the receiver stalls, the result is held on out_ch and no further
// operation is accepted until it has been taken.
module bounded_fifo_with_take_marker_core #(
  parameter int DEPTH       = bfq_pkg::DEPTH_DEF,
  parameter int ENTRY_WIDTH = bfq_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [bfq_pkg::CFG_W-1:0] cfg_wr_data,
  bfq_in_if.sink                    in_ch,
  bfq_out_if.source                 out_ch
);

  bfq_pkg::bfq_cmd_t  cmd;
  bfq_pkg::bfq_stat_t stat;

  bfq_dp #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_ch.payload),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (out_ch.payload)
  );

  bfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  // A new transaction is only taken when the pending result leaves this cycle.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!out_ch.valid || out_ch.ready))
    else $error("input accepted while a stalled result would be overwritten");

  // An operation that reads the memory presents its result after the ST_READ state.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && stat.need_read) |-> ##2 out_ch.valid)
    else $error("read result not presented after the memory read cycle");

  // Only a successful take or peek carries an entry word.
  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.payload.entry_valid)
      |-> (out_ch.payload.status == bfq_pkg::CODE_W'(bfq_pkg::STS_OK)))
    else $error("entry returned with a non-ok status");

  // Execute and capture never fall in the same cycle.
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exec && cmd.capture))
    else $error("execute and capture commands overlap");

endmodule

// ===== sv/bfq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bfq_ram #(
  parameter int WIDTH = bfq_pkg::ENTRY_WIDTH_DEF,
  parameter int DEPTH = bfq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/bfq_ctrl.sv =====
// Controller: handshake control and the read-wait sequencing.
module bfq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  input  bfq_pkg::bfq_stat_t  stat,
  output bfq_pkg::bfq_cmd_t   cmd,
  output logic                in_ready,
  output logic                out_valid
);

  bfq_pkg::bfq_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      bfq_pkg::ST_IDLE: begin
        // A new transaction may enter when the result register is empty or frees this cycle.
        in_ready = !out_valid_r || out_ready;
        cmd.exec = in_valid && in_ready;
        if (cmd.exec) begin
          if (stat.need_read) begin
            state_nxt = bfq_pkg::ST_READ;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      bfq_pkg::ST_READ: begin
        cmd.capture   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = bfq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bfq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/bfq_dp.sv =====
// Datapath: ring pointers, count, marker state, capacity register and result register.
module bfq_dp #(
  parameter int DEPTH       = bfq_pkg::DEPTH_DEF,
  parameter int ENTRY_WIDTH = bfq_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [bfq_pkg::CFG_W-1:0]   cfg_wr_data,
  input  bfq_pkg::bfq_in_t            in_data,
  input  bfq_pkg::bfq_cmd_t           cmd,
  output bfq_pkg::bfq_stat_t          stat,
  output bfq_pkg::bfq_out_t           out_data
);

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LIM_W  = (CNT_W > bfq_pkg::CFG_W) ? CNT_W : bfq_pkg::CFG_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
  localparam logic [LIM_W-1:0]  DEPTH_LIM = LIM_W'(DEPTH);

  logic [SLOT_W-1:0]         head_r, head_nxt;
  logic [SLOT_W-1:0]         tail_r, tail_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      mark_en_r, mark_en_nxt;
  logic [SLOT_W-1:0]         mark_slot_r, mark_slot_nxt;
  logic                      mark_reached_r, mark_reached_nxt;
  logic [bfq_pkg::CFG_W-1:0] max_entries_r;

  bfq_pkg::bfq_status_t      status_r, status_nxt;
  logic                      ent_valid_r, ent_valid_nxt;
  logic [bfq_pkg::DATA_W-1:0] entry_out_r;
  logic [CNT_W-1:0]          occ_r;
  logic                      held_r;

  logic                      mem_we;
  logic [ENTRY_WIDTH-1:0]    mem_rdata;
  logic [LIM_W-1:0]          max_ext;
  logic [LIM_W-1:0]          limit;
  logic [LIM_W-1:0]          count_ext;

  assign max_ext   = LIM_W'(max_entries_r);
  assign limit     = (max_ext == '0 || max_ext > DEPTH_LIM) ? DEPTH_LIM : max_ext;
  assign count_ext = LIM_W'(count_r);

  always_comb begin
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    count_nxt        = count_r;
    mark_en_nxt      = mark_en_r;
    mark_slot_nxt    = mark_slot_r;
    mark_reached_nxt = mark_reached_r;
    status_nxt       = bfq_pkg::STS_OK;
    ent_valid_nxt    = 1'b0;
    mem_we           = 1'b0;
    unique case (bfq_pkg::bfq_op_t'(in_data.opcode))
      bfq_pkg::OP_WRITE: begin
        if (in_data.action_kind <= bfq_pkg::KIND_UNREGISTER) begin
          status_nxt = bfq_pkg::STS_IGNORED;
        end else if (count_ext >= limit) begin
          status_nxt = bfq_pkg::STS_FULL;
        end else begin
          mem_we = 1'b1;
          // An enabled marker follows every new tail entry.
          if (mark_en_r) begin
            mark_slot_nxt = tail_r;
          end
          tail_nxt  = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      bfq_pkg::OP_TAKE: begin
        if (count_r == '0) begin
          status_nxt = bfq_pkg::STS_EMPTY;
        end else if (mark_reached_r) begin
          status_nxt = bfq_pkg::STS_HELD;
        end else begin
          ent_valid_nxt = 1'b1;
          if (mark_en_r && mark_slot_r == head_r) begin
            mark_reached_nxt = 1'b1;
          end
          head_nxt  = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      bfq_pkg::OP_PEEK: begin
        if (count_r == '0) begin
          status_nxt = bfq_pkg::STS_EMPTY;
        end else begin
          ent_valid_nxt = 1'b1;
        end
      end
      bfq_pkg::OP_SET_MARK: begin
        if (count_r == '0) begin
          mark_en_nxt = 1'b0;
        end else begin
          mark_en_nxt   = 1'b1;
          mark_slot_nxt = (tail_r == '0) ? LAST_SLOT : tail_r - 1'b1;
        end
        mark_reached_nxt = 1'b0;
      end
      bfq_pkg::OP_CLR_MARK: begin
        mark_en_nxt      = 1'b0;
        mark_reached_nxt = 1'b0;
      end
      default: begin
        status_nxt = bfq_pkg::STS_IGNORED;
      end
    endcase
  end

  assign stat.need_read = ent_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r         <= '0;
      tail_r         <= '0;
      count_r        <= '0;
      mark_en_r      <= 1'b0;
      mark_slot_r    <= '0;
      mark_reached_r <= 1'b0;
      max_entries_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_entries_r <= cfg_wr_data;
      end
      if (cmd.exec) begin
        head_r         <= head_nxt;
        tail_r         <= tail_nxt;
        count_r        <= count_nxt;
        mark_en_r      <= mark_en_nxt;
        mark_slot_r    <= mark_slot_nxt;
        mark_reached_r <= mark_reached_nxt;
      end
    end
  end

  // Result register; for take and peek the entry word is loaded in ST_READ, in the cycle after the other fields.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r    <= status_nxt;
      ent_valid_r <= ent_valid_nxt;
      occ_r       <= count_nxt;
      held_r      <= mark_reached_nxt;
      entry_out_r <= '0;
    end else if (cmd.capture) begin
      entry_out_r <= bfq_pkg::DATA_W'(mem_rdata);
    end
  end

  bfq_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.exec && mem_we),
    .wr_addr (tail_r),
    .wr_data (in_data.entry_data[ENTRY_WIDTH-1:0]),
    .rd_addr (head_r),
    .rd_data (mem_rdata)
  );

  assign out_data.status         = bfq_pkg::CODE_W'(status_r);
  assign out_data.entry_valid    = ent_valid_r;
  assign out_data.entry_out      = entry_out_r;
  assign out_data.occupancy      = bfq_pkg::OCC_W'(occ_r);
  assign out_data.data_available = (occ_r != '0);
  assign out_data.marker_held    = held_r;

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the bounded FIFO with take marker: directed and random queue operations.
`timescale 1ns / 100ps

module tb;

  localparam int CODE_W = bfq_pkg::CODE_W;
  localparam int DATA_W = bfq_pkg::DATA_W;
  localparam int CFG_W  = bfq_pkg::CFG_W;
  localparam int OCC_W  = bfq_pkg::OCC_W;

  localparam int RING_DEPTH  = bfq_pkg::DEPTH_DEF;
  localparam int CYCLE_LIMIT = 250000;
  localparam int RANDOM_OPS  = 680;
  localparam int OPS_PER_PHASE = 85;
  localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};
  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  bfq_in_if  in_if ();
  bfq_out_if out_if ();

  bounded_fifo_with_take_marker_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_if),
    .out_ch     (out_if)
  );

  // Shadow copy of the queue state.
  logic [DATA_W-1:0] ring_mem [RING_DEPTH];
  logic [5:0]        ring_head;
  logic [5:0]        ring_tail;
  logic [OCC_W-1:0]  ring_count;
  logic              mark_on;
  logic [5:0]        mark_slot;
  logic              mark_taken;
  logic [CFG_W-1:0]  cap_limit;

  bfq_pkg::bfq_out_t awaited_replies [$];
  int       err_count;
  int       cycle_count;
  int       burst_left;
  int       rx_left;
  int       rx_mode;
  logic     rx_toggle;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Applies one operation to the shadow queue and returns the reply it must produce.
  function automatic bfq_pkg::bfq_out_t queue_apply(input bfq_pkg::bfq_in_t op_in);
    bfq_pkg::bfq_out_t r;
    logic [6:0]        limit;
    r = '0;
    r.status = bfq_pkg::STS_OK;
    limit = (cap_limit == 0 || cap_limit > RING_DEPTH) ? 7'(RING_DEPTH) : cap_limit;
    case (op_in.opcode)
      bfq_pkg::OP_WRITE: begin
        if (op_in.action_kind <= bfq_pkg::KIND_UNREGISTER) begin
          r.status = bfq_pkg::STS_IGNORED;
        end else if (ring_count >= limit) begin
          r.status = bfq_pkg::STS_FULL;
        end else begin
          ring_mem[ring_tail] = op_in.entry_data;
          if (mark_on) mark_slot = ring_tail;
          ring_tail = ring_tail + 6'd1;
          ring_count = ring_count + 7'd1;
        end
      end
      bfq_pkg::OP_TAKE: begin
        if (ring_count == 0) begin
          r.status = bfq_pkg::STS_EMPTY;
        end else if (mark_taken) begin
          r.status = bfq_pkg::STS_HELD;
        end else begin
          r.entry_out = ring_mem[ring_head];
          r.entry_valid = 1'b1;
          if (mark_on && mark_slot == ring_head) mark_taken = 1'b1;
          ring_head = ring_head + 6'd1;
          ring_count = ring_count - 7'd1;
        end
      end
      bfq_pkg::OP_PEEK: begin
        if (ring_count == 0) begin
          r.status = bfq_pkg::STS_EMPTY;
        end else begin
          r.entry_out = ring_mem[ring_head];
          r.entry_valid = 1'b1;
        end
      end
      bfq_pkg::OP_SET_MARK: begin
        if (ring_count == 0) begin
          mark_on = 1'b0;
        end else begin
          mark_on = 1'b1;
          mark_slot = ring_tail - 6'd1;
        end
        mark_taken = 1'b0;
      end
      bfq_pkg::OP_CLR_MARK: begin
        mark_on = 1'b0;
        mark_taken = 1'b0;
      end
      default: begin
        r.status = bfq_pkg::STS_IGNORED;
      end
    endcase
    r.occupancy = ring_count;
    r.data_available = (ring_count != 0);
    r.marker_held = mark_taken;
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Tracks accepted transactions on both channels and checks each reply in order.
  always @(posedge clk) begin
    bfq_pkg::bfq_out_t want;
    bfq_pkg::bfq_out_t got;
    if (!rst_n) begin
      ring_head = '0;
      ring_tail = '0;
      ring_count = '0;
      mark_on = 1'b0;
      mark_slot = '0;
      mark_taken = 1'b0;
      cap_limit = '0;
    end else begin
      if (cfg_wr_en) cap_limit = cfg_wr_data;
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        if (awaited_replies.size() == 0) begin
          $error("reply transaction with nothing outstanding: status %0d", got.status);
          err_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            err_count++;
          end
          if (got.entry_valid !== want.entry_valid) begin
            $error("entry_valid expected %0d actual %0d", want.entry_valid, got.entry_valid);
            err_count++;
          end
          if (got.entry_out !== want.entry_out) begin
            $error("entry_out expected %h actual %h", want.entry_out, got.entry_out);
            err_count++;
          end
          if (got.occupancy !== want.occupancy) begin
            $error("occupancy expected %0d actual %0d", want.occupancy, got.occupancy);
            err_count++;
          end
          if (got.data_available !== want.data_available) begin
            $error("data_available expected %0d actual %0d",
                   want.data_available, got.data_available);
            err_count++;
          end
          if (got.marker_held !== want.marker_held) begin
            $error("marker_held expected %0d actual %0d", want.marker_held, got.marker_held);
            err_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) awaited_replies.push_back(queue_apply(in_if.payload));
    end
  end

  // The receiver switches between always ready, random, sparse and alternating stalls.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(8, 80);
    end
    rx_left = rx_left - 1;
    rx_toggle = ~rx_toggle;
    case (rx_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: out_if.ready <= ($urandom_range(0, 3) == 0);
      default: out_if.ready <= rx_toggle;
    endcase
  end

  task automatic send_op(input logic [CODE_W-1:0] op, input logic [CODE_W-1:0] kind,
                         input logic [DATA_W-1:0] data);
    bfq_pkg::bfq_in_t item;
    int               gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
    end
    burst_left = burst_left - 1;
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    item.opcode = op;
    item.action_kind = kind;
    item.entry_data = data;
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.payload <= item;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CFG_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_basic_ops();
    send_op(bfq_pkg::OP_TAKE, 3'd2, '0);
    send_op(bfq_pkg::OP_PEEK, 3'd2, '0);
    send_op(bfq_pkg::OP_SET_MARK, 3'd0, '0);
    send_op(bfq_pkg::OP_CLR_MARK, 3'd0, '0);
    send_op(bfq_pkg::OP_WRITE, 3'd0, 64'h1111);
    send_op(bfq_pkg::OP_WRITE, bfq_pkg::KIND_UNREGISTER, 64'h2222);
    for (int c = bfq_pkg::OP_CLR_MARK + 1; c <= CODE_MAX; c++) begin
      send_op(CODE_W'(c), 3'd5, ALL_ONES);
    end
    send_op(bfq_pkg::OP_WRITE, 3'd2, '0);
    send_op(bfq_pkg::OP_WRITE, CODE_MAX, ALL_ONES);
    send_op(bfq_pkg::OP_PEEK, 3'd0, '0);
    send_op(bfq_pkg::OP_TAKE, 3'd0, '0);
    send_op(bfq_pkg::OP_TAKE, 3'd0, '0);
  endtask

  task automatic test_marker();
    send_op(bfq_pkg::OP_WRITE, 3'd3, 64'hA5A5_0000_0000_0001);
    send_op(bfq_pkg::OP_WRITE, 3'd4, 64'hA5A5_0000_0000_0002);
    send_op(bfq_pkg::OP_SET_MARK, 3'd0, '0);
    // The marker follows the tail while it is enabled.
    send_op(bfq_pkg::OP_WRITE, 3'd5, 64'hA5A5_0000_0000_0003);
    send_op(bfq_pkg::OP_TAKE, 3'd0, '0);
    send_op(bfq_pkg::OP_TAKE, 3'd0, '0);
    send_op(bfq_pkg::OP_TAKE, 3'd0, '0);
    // A write while held moves the marker but takes stay blocked.
    send_op(bfq_pkg::OP_WRITE, 3'd6, 64'hA5A5_0000_0000_0004);
    send_op(bfq_pkg::OP_TAKE, 3'd0, '0);
    send_op(bfq_pkg::OP_PEEK, 3'd0, '0);
    send_op(bfq_pkg::OP_SET_MARK, 3'd0, '0);
    send_op(bfq_pkg::OP_TAKE, 3'd0, '0);
    send_op(bfq_pkg::OP_CLR_MARK, 3'd0, '0);
    send_op(bfq_pkg::OP_TAKE, 3'd0, '0);
  endtask

  task automatic test_capacity();
    set_capacity(7'd1);
    send_op(bfq_pkg::OP_WRITE, 3'd2, {$urandom, $urandom});
    send_op(bfq_pkg::OP_WRITE, 3'd3, {$urandom, $urandom});
    send_op(bfq_pkg::OP_TAKE, 3'd0, '0);
    set_capacity(7'(RING_DEPTH));
    for (int i = 0; i <= RING_DEPTH; i++) begin
      send_op(bfq_pkg::OP_WRITE, 3'd7, {$urandom, $urandom});
    end
    send_op(bfq_pkg::OP_PEEK, 3'd0, '0);
    // Lowering the limit below the current fill rejects further writes.
    set_capacity(7'd3);
    send_op(bfq_pkg::OP_WRITE, 3'd2, {$urandom, $urandom});
    set_capacity(7'd0);
    send_op(bfq_pkg::OP_WRITE, 3'd2, {$urandom, $urandom});
    for (int i = 0; i <= RING_DEPTH; i++) send_op(bfq_pkg::OP_TAKE, 3'd0, '0);
    set_capacity({CFG_W{1'b1}});
    for (int i = 0; i < 5; i++) send_op(bfq_pkg::OP_WRITE, 3'd4, {$urandom, $urandom});
    send_op(bfq_pkg::OP_SET_MARK, 3'd0, '0);
    for (int i = 0; i < 6; i++) send_op(bfq_pkg::OP_TAKE, 3'd0, '0);
  endtask

  task automatic test_random();
    logic [CODE_W-1:0] op;
    logic [CODE_W-1:0] kind;
    logic [DATA_W-1:0] data;
    int                wr_pct;
    int                done;
    for (int phase = 0; phase < RANDOM_OPS / OPS_PER_PHASE; phase++) begin
      case ($urandom_range(0, 5))
        0: set_capacity(7'd0);
        1: set_capacity(7'd1);
        2: set_capacity(7'(RING_DEPTH));
        3: set_capacity({CFG_W{1'b1}});
        4: set_capacity(CFG_W'($urandom_range(2, 8)));
        default: set_capacity(CFG_W'($urandom_range(0, 127)));
      endcase
      wr_pct = $urandom_range(25, 75);
      done = 0;
      while (done < OPS_PER_PHASE) begin
        kind = CODE_W'($urandom_range(0, CODE_MAX));
        if ($urandom_range(0, 99) < wr_pct) begin
          op = bfq_pkg::OP_WRITE;
          if ($urandom_range(0, 9) != 0) begin
            kind = CODE_W'($urandom_range(bfq_pkg::KIND_UNREGISTER + 1, CODE_MAX));
          end
        end else begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: op = bfq_pkg::OP_TAKE;
            11, 12, 13: op = bfq_pkg::OP_PEEK;
            14, 15, 16: op = bfq_pkg::OP_SET_MARK;
            17: op = bfq_pkg::OP_CLR_MARK;
            18: op = CODE_W'($urandom_range(bfq_pkg::OP_CLR_MARK + 1, CODE_MAX));
            default: op = CODE_W'($urandom_range(0, CODE_MAX));
          endcase
        end
        case ($urandom_range(0, 15))
          0: data = '0;
          1: data = ALL_ONES;
          default: data = {$urandom, $urandom};
        endcase
        send_op(op, kind, data);
        if (op <= bfq_pkg::OP_CLR_MARK &&
            !(op == bfq_pkg::OP_WRITE && kind <= bfq_pkg::KIND_UNREGISTER)) done++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    err_count = 0;
    cycle_count = 0;
    burst_left = 0;
    rx_left = 0;
    rx_mode = 0;
    rx_toggle = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_marker();
    test_capacity();
    test_random();
    wait_idle();
    repeat (6) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bfq_pkg.sv
sv/bfq_if.sv
sv/bfq_ram.sv
sv/bfq_ctrl.sv
sv/bfq_dp.sv
sv/bounded_fifo_with_take_marker_core.sv
tb/sv/tb.sv
